// ===== rtl/core/pcpfl_pkg.sv =====
// Package for the per-CPU page free-list allocator.
// Holds the page geometry, operation and status codes, and register indexes.
// Depends on nothing; the top level imports it.
package pcpfl_pkg;

  // Page geometry: 4 KiB pages.
  localparam int PAGE_SHIFT = 12;

  typedef logic [31:0] addr_t;
  typedef logic [1:0]  status_t;
  typedef logic        func_t;
  typedef logic        reg_index_t;

  // Operation codes.
  localparam func_t FUNC_ALLOC = 1'b0;
  localparam func_t FUNC_FREE  = 1'b1;

  // Status codes.
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_EMPTY   = 2'd1;
  localparam status_t ST_BADADDR = 2'd2;

  // Configuration register indexes.
  localparam reg_index_t REG_MEM_BASE = 1'b0;
  localparam reg_index_t REG_MEM_TOP  = 1'b1;

  // Register reset values.
  localparam addr_t MEM_BASE_RESET = 32'h8000_0000;
  localparam addr_t MEM_TOP_RESET  = 32'h8800_0000;

endpackage

// ===== rtl/core/per_cpu_page_free_list_allocator.sv =====
// Per-CPU page free-list allocator: top level.
// Depends on pcpfl_pkg and pcpfl_ram (next-link store).
//
// Usage:
//   The input channel (in_valid / in_stall) carries one request per
//   transaction: func selects allocate or free, cpu_id names the CPU whose
//   list is used first, page_addr is the page to free. The output channel
//   (out_valid / out_stall) returns exactly one transaction per request:
//   result_addr and status.
//   A free is checked (alignment, base, top, page count) and pushed on the
//   CPU's list in the EXEC state, which also yields its result. An allocate
//   pops the CPU's list, or steals from the other lists in rotating order
//   from cpu+1; its result comes from the LINK state after EXEC, which waits
//   for the registered read of the next-link RAM that yields the new list
//   head. If every list is empty, EXEC returns ST_EMPTY. One request is in
//   flight at a time; the next request is accepted as soon as the previous
//   result sits in the output register, even while the receiver still
//   stalls it. If the output register is still full when a result is ready,
//   the result waits in a holding register. Reset (rst, synchronous) empties
//   every list at once through the head valid bits; the next-link RAM needs
//   no clearing pass. mem_base and mem_top are written through cfg_we /
//   cfg_index / cfg_data; the user must write them only while idle, as the
//   block does not enforce it.
module per_cpu_page_free_list_allocator #(
  parameter int NUM_CPUS  = 8,
  parameter int NUM_PAGES = 32768
) (
  input  logic                clk,
  input  logic                rst,
  // Configuration write port.
  input  logic                cfg_we,
  input  pcpfl_pkg::reg_index_t cfg_index,
  input  pcpfl_pkg::addr_t    cfg_data,
  // Request channel.
  input  logic                in_valid,
  output logic                in_stall,
  input  pcpfl_pkg::func_t    func,
  input  logic [2:0]          cpu_id,
  input  pcpfl_pkg::addr_t    page_addr,
  // Result channel.
  output logic                out_valid,
  input  logic                out_stall,
  output pcpfl_pkg::addr_t    result_addr,
  output pcpfl_pkg::status_t  status
);

  import pcpfl_pkg::*;

  localparam int CW  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int CW1 = CW + 1;
  localparam int PW  = $clog2(NUM_PAGES);
  localparam int LW  = PW + 1;

  // Sequencer state codes.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LINK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]          state;
  logic [1:0]          state_next;

  // Configuration registers.
  addr_t               mem_base;
  addr_t               mem_top;
  addr_t               base_al;

  // Captured request.
  func_t               op_func;
  logic [CW-1:0]       op_cpu;
  addr_t               op_addr;

  // List heads: index plus valid bit per CPU.
  logic [PW-1:0]       head_idx [NUM_CPUS];
  logic [NUM_CPUS-1:0] head_valid;

  // Pop in progress.
  logic [CW-1:0]       pop_cpu;
  logic [PW-1:0]       pop_idx;

  // Holding register for a result that found the output register full.
  addr_t               hold_addr;
  status_t             hold_status;

  // Search and check results.
  logic                found;
  logic [CW-1:0]       sel_cpu;
  addr_t               free_diff;
  logic                free_ok;
  logic [PW-1:0]       free_idx;

  // Result ready this cycle.
  logic                res_ready;
  addr_t               res_addr;
  status_t             res_status;
  logic                out_free;
  logic                in_accept;

  // Next-link RAM ports.
  logic                ram_we;
  logic [PW-1:0]       ram_waddr;
  logic [LW-1:0]       ram_wdata;
  logic [PW-1:0]       ram_raddr;
  logic [LW-1:0]       ram_rdata;

  // cpu_id taken modulo NUM_CPUS by repeated subtraction on three bits.
  function automatic logic [CW-1:0] cpu_mod(input logic [2:0] v);
    logic [2:0] r;
    r = v;
    for (int k = 0; k < 8; k++) begin
      if (int'(r) >= NUM_CPUS) begin
        r = r - 3'(NUM_CPUS);
      end
    end
    return CW'(r);
  endfunction

  assign base_al   = {mem_base[31:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      mem_base <= MEM_BASE_RESET;
      mem_top  <= MEM_TOP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MEM_BASE: mem_base <= cfg_data;
        REG_MEM_TOP:  mem_top  <= cfg_data;
        default:      mem_top  <= mem_top;
      endcase
    end
  end

  // Capture a request when it is accepted.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_func <= func;
      op_cpu  <= cpu_mod(cpu_id);
      op_addr <= page_addr;
    end
  end

  // Free address check and page index.
  assign free_diff = op_addr - base_al;
  assign free_idx  = free_diff[PW+PAGE_SHIFT-1:PAGE_SHIFT];
  assign free_ok   = (op_addr[PAGE_SHIFT-1:0] == '0) && (op_addr >= base_al) &&
                     (op_addr < mem_top) &&
                     ((free_diff >> PAGE_SHIFT) < 32'(NUM_PAGES));

  // Rotating-priority search for the first non-empty list from op_cpu.
  always_comb begin : search
    logic [CW1-1:0] cand;
    found   = 1'b0;
    sel_cpu = '0;
    for (int i = NUM_CPUS - 1; i >= 0; i--) begin
      cand = {1'b0, op_cpu} + CW1'(i);
      if (int'(cand) >= NUM_CPUS) begin
        cand = cand - CW1'(NUM_CPUS);
      end
      if (head_valid[cand[CW-1:0]]) begin
        found   = 1'b1;
        sel_cpu = cand[CW-1:0];
      end
    end
  end

  // Next-link RAM access: push writes the old head, pop reads the link.
  assign ram_we    = (state == S_EXEC) && (op_func == FUNC_FREE) && free_ok;
  assign ram_waddr = free_idx;
  assign ram_wdata = {head_valid[op_cpu], head_valid[op_cpu] ? head_idx[op_cpu] : PW'(0)};
  assign ram_raddr = head_idx[sel_cpu];

  pcpfl_ram #(
    .WIDTH(LW),
    .DEPTH(NUM_PAGES)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Result selection for the current state.
  always_comb begin
    res_ready  = 1'b0;
    res_addr   = '0;
    res_status = ST_OK;
    unique case (state)
      S_EXEC: begin
        if (op_func == FUNC_FREE) begin
          res_ready  = 1'b1;
          res_status = free_ok ? ST_OK : ST_BADADDR;
        end else if (!found) begin
          res_ready  = 1'b1;
          res_status = ST_EMPTY;
        end
      end
      S_LINK: begin
        res_ready = 1'b1;
        res_addr  = base_al + (addr_t'(pop_idx) << PAGE_SHIFT);
      end
      S_DONE: begin
        res_ready  = 1'b1;
        res_addr   = hold_addr;
        res_status = hold_status;
      end
      default: begin
        res_ready = 1'b0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_accept) state_next = S_EXEC;
      S_EXEC: begin
        if (res_ready) begin
          state_next = out_free ? S_IDLE : S_DONE;
        end else begin
          state_next = S_LINK;
        end
      end
      S_LINK: state_next = out_free ? S_IDLE : S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Head updates: push in EXEC, pop completes in LINK.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= '0;
    end else if (ram_we) begin
      head_idx[op_cpu]   <= free_idx;
      head_valid[op_cpu] <= 1'b1;
    end else if (state == S_LINK) begin
      head_idx[pop_cpu]   <= ram_rdata[LW-1] ? ram_rdata[PW-1:0] : PW'(0);
      head_valid[pop_cpu] <= ram_rdata[LW-1];
    end
  end

  // Remember the list being popped while the link read is in flight.
  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      pop_cpu <= sel_cpu;
      pop_idx <= head_idx[sel_cpu];
    end
  end

  // Park a result when the output register is still occupied.
  always_ff @(posedge clk) begin
    if (res_ready && !out_free && state != S_DONE) begin
      hold_addr   <= res_addr;
      hold_status <= res_status;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && out_free) begin
      result_addr <= res_addr;
      status      <= res_status;
    end
  end

  // An accepted request always moves straight to execution.
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == S_EXEC))
    else $error("accepted request did not enter execution");

  // The link read stage only follows an allocate that found a page.
  a_link_after_pop: assert property (@(posedge clk) disable iff (rst)
    (state == S_LINK) |-> ($past(state) == S_EXEC) && (op_func == FUNC_ALLOC))
    else $error("link stage entered without a pop");

  // A free never issues a link read.
  a_free_no_link: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EXEC) && (op_func == FUNC_FREE)) |=> (state != S_LINK))
    else $error("free request entered link stage");

  // A held result leaves DONE only when the output register can take it.
  a_done_waits: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && out_valid && out_stall) |=> (state == S_DONE))
    else $error("held result dropped while output stalled");

endmodule

// ===== rtl/core/pcpfl_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Used for the per-page next-link store; depends on nothing.
module pcpfl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
